// File: rtl/core/sbvt_pkg.sv
`default_nettype none
package sbvt_pkg;

    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 10;
    localparam int GAIN_BITS   = 6;
    localparam int PULSE_BITS  = 16;
    localparam int TIME_BITS   = 32;
    localparam int CFG_DATA_BITS = 16;

    localparam int WIN_LOG  = $clog2(WINDOW);
    localparam int SUM_BITS = SAMPLE_BITS + WIN_LOG;

    // Exact division of the running sum by WINDOW: floor(sum * RECIP >> RECIP_SHIFT)
    localparam int RECIP_SHIFT = SUM_BITS + WIN_LOG;
    localparam int RECIP_BITS  = SUM_BITS + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Gain is in tenths, so the current sample is scaled by ten before the compare
    localparam int SCALE_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam logic [SCALE_BITS-1:0] GAIN_SCALE = SCALE_BITS'(10);

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(13);
    localparam logic [PULSE_BITS-1:0] PULSE_RESET = PULSE_BITS'(300);

    typedef enum logic [0:0] {
        REG_GAIN_TENTHS = 1'b0,
        REG_PULSE_MS    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] baseline_sample;
        logic [SAMPLE_BITS-1:0] current_sample;
        logic [TIME_BITS-1:0]   time_ms;
    } sample_t;

    typedef struct packed {
        logic                   vibrate;
        logic                   trigger_event;
        logic [SAMPLE_BITS-1:0] window_average;
    } result_t;

    // What the window stage hands to the detector
    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [SAMPLE_BITS-1:0] current_sample;
        logic [TIME_BITS-1:0]   time_ms;
    } window_out_t;

    typedef struct packed {
        logic shift;
        logic seed;
    } cell_ctrl_t;

    typedef struct packed {
        logic load_avg;
        logic load_out;
    } stage_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/sbvt_cell.sv
`default_nettype none
module sbvt_cell (
    input  wire                                 clk,
    input  sbvt_pkg::cell_ctrl_t                ctrl,
    input  wire  [sbvt_pkg::SAMPLE_BITS-1:0]    seed_value,
    input  wire  [sbvt_pkg::SAMPLE_BITS-1:0]    prev,
    output logic [sbvt_pkg::SAMPLE_BITS-1:0]    value
);

    logic [sbvt_pkg::SAMPLE_BITS-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.seed)
        begin
            value_reg <= seed_value;
        end
        else if (ctrl.shift)
        begin
            value_reg <= prev;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

// File: rtl/core/sbvt_window.sv
`default_nettype none
module sbvt_window (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     load,
    input  sbvt_pkg::sample_t       sample,
    output sbvt_pkg::window_out_t   win
);

    logic [sbvt_pkg::SAMPLE_BITS-1:0] chain [sbvt_pkg::WINDOW];
    logic [sbvt_pkg::SUM_BITS-1:0]    sum_reg;
    logic [sbvt_pkg::SUM_BITS-1:0]    sum_next;
    logic                             seeded_reg;
    logic [sbvt_pkg::SAMPLE_BITS-1:0] cur_reg;
    logic [sbvt_pkg::TIME_BITS-1:0]   time_reg;
    sbvt_pkg::cell_ctrl_t             ctrl;

    assign ctrl.shift = load;
    assign ctrl.seed  = load && !seeded_reg;

    genvar g;
    generate
        for (g = 0; g < sbvt_pkg::WINDOW; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                sbvt_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .seed_value (sample.baseline_sample),
                    .prev       (sample.baseline_sample),
                    .value      (chain[g])
                );
            end
            else
            begin : g_body
                sbvt_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .seed_value (sample.baseline_sample),
                    .prev       (chain[g-1]),
                    .value      (chain[g])
                );
            end
        end
    endgenerate

    // The last cell holds the sample that drops out of the window
    always_comb
    begin
        if (seeded_reg)
        begin
            sum_next = sum_reg - sbvt_pkg::SUM_BITS'(chain[sbvt_pkg::WINDOW-1])
                     + sbvt_pkg::SUM_BITS'(sample.baseline_sample);
        end
        else
        begin
            sum_next = sbvt_pkg::SUM_BITS'(sample.baseline_sample)
                     * sbvt_pkg::SUM_BITS'(sbvt_pkg::WINDOW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            seeded_reg <= 1'b0;
        end
        else if (load)
        begin
            sum_reg    <= sum_next;
            seeded_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg  <= sample.current_sample;
            time_reg <= sample.time_ms;
        end
    end

    assign win.sum            = sum_reg;
    assign win.current_sample = cur_reg;
    assign win.time_ms        = time_reg;

    a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> seeded_reg)
        else $error("window not marked seeded after a request");

    a_seed_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.seed |=> sum_reg == sbvt_pkg::SUM_BITS'($past(sample.baseline_sample))
                               * sbvt_pkg::SUM_BITS'(sbvt_pkg::WINDOW))
        else $error("seeded sum is not the first sample times the window");

endmodule
`default_nettype wire

// File: rtl/core/sbvt_detect.sv
`default_nettype none
module sbvt_detect (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  sbvt_pkg::stage_ctrl_t               ctrl,
    input  sbvt_pkg::window_out_t               win,
    input  wire  [sbvt_pkg::GAIN_BITS-1:0]      gain_tenths,
    input  wire  [sbvt_pkg::PULSE_BITS-1:0]     pulse_ms,
    output sbvt_pkg::result_t                   result
);

    logic [sbvt_pkg::PROD_BITS-1:0]   recip_prod;
    logic [sbvt_pkg::SAMPLE_BITS-1:0] avg_reg;
    logic [sbvt_pkg::SAMPLE_BITS-1:0] cur_reg;
    logic [sbvt_pkg::TIME_BITS-1:0]   time_reg;

    logic [sbvt_pkg::SCALE_BITS-1:0]  avg_scaled;
    logic [sbvt_pkg::SCALE_BITS-1:0]  cur_scaled;
    logic                             trig;
    logic                             expired;
    logic                             active_next;

    logic                             active_reg;
    logic [sbvt_pkg::TIME_BITS-1:0]   start_reg;
    sbvt_pkg::result_t                out_reg;

    // Average stage: divide by the window through the reciprocal
    assign recip_prod = sbvt_pkg::PROD_BITS'(win.sum) * sbvt_pkg::PROD_BITS'(sbvt_pkg::RECIP);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_avg)
        begin
            avg_reg  <= recip_prod[sbvt_pkg::RECIP_SHIFT +: sbvt_pkg::SAMPLE_BITS];
            cur_reg  <= win.current_sample;
            time_reg <= win.time_ms;
        end
    end

    // Threshold and one-shot stage
    assign avg_scaled = sbvt_pkg::SCALE_BITS'(avg_reg) * sbvt_pkg::SCALE_BITS'(gain_tenths);
    assign cur_scaled = sbvt_pkg::SCALE_BITS'(cur_reg) * sbvt_pkg::GAIN_SCALE;
    assign trig       = avg_scaled < cur_scaled;

    assign expired = ({1'b0, start_reg} + {{(sbvt_pkg::TIME_BITS + 1
                       - sbvt_pkg::PULSE_BITS){1'b0}}, pulse_ms})
                     < {1'b0, time_reg};

    // A pulse that starts on this request cannot also end on it
    always_comb
    begin
        priority if (trig)
        begin
            active_next = 1'b1;
        end
        else if (active_reg && expired)
        begin
            active_next = 1'b0;
        end
        else
        begin
            active_next = active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (ctrl.load_out)
        begin
            active_reg <= active_next;
            if (trig)
            begin
                start_reg <= time_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_reg.vibrate        <= active_next;
            out_reg.trigger_event  <= trig;
            out_reg.window_average <= avg_reg;
        end
    end

    assign result = out_reg;

    a_event_drives: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> (!out_reg.trigger_event || out_reg.vibrate))
        else $error("trigger event without vibrator on");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out && trig |=> active_reg && start_reg == $past(time_reg))
        else $error("trigger did not restart the pulse");

endmodule
`default_nettype wire

// File: rtl/core/sound_burst_vibration_trigger.sv
`default_nettype none
// Moving-average burst detector with a one-shot vibrator pulse. Each request
// carries a baseline sample, a current sample and a millisecond timestamp and
// yields exactly one result. A new request is taken every clock cycle while
// result_ready keeps the pipeline moving; the result is registered in the window,
// average and output stages in turn. The row of window cells shifts once per
// request while the running sum is updated, followed by a reciprocal-multiply average
// stage and a threshold/pulse stage. The first request after reset fills every
// window cell with its baseline sample. Write gain_tenths and pulse_ms only
// while no request is in flight.
module sound_burst_vibration_trigger (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_write,
    input  sbvt_pkg::cfg_index_t                    cfg_index,
    input  wire  [sbvt_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  wire                                     sample_valid,
    output logic                                    sample_ready,
    input  sbvt_pkg::sample_t                       sample,
    output logic                                    result_valid,
    input  wire                                     result_ready,
    output sbvt_pkg::result_t                       result
);

    logic [sbvt_pkg::GAIN_BITS-1:0]  gain_reg;
    logic [sbvt_pkg::PULSE_BITS-1:0] pulse_reg;

    logic win_valid_reg;
    logic avg_valid_reg;
    logic out_valid_reg;
    logic en_win;
    logic en_avg;
    logic en_out;
    logic accept;

    sbvt_pkg::window_out_t win;
    sbvt_pkg::stage_ctrl_t stage_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= sbvt_pkg::GAIN_RESET;
            pulse_reg <= sbvt_pkg::PULSE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sbvt_pkg::REG_GAIN_TENTHS: gain_reg  <= cfg_data[sbvt_pkg::GAIN_BITS-1:0];
                sbvt_pkg::REG_PULSE_MS:    pulse_reg <= cfg_data[sbvt_pkg::PULSE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Each stage advances when it is empty or the stage after it moves
    assign en_out = !out_valid_reg || result_ready;
    assign en_avg = !avg_valid_reg || en_out;
    assign en_win = !win_valid_reg || en_avg;
    assign accept = sample_valid && en_win;

    assign sample_ready = en_win;
    assign result_valid = out_valid_reg;

    assign stage_ctrl.load_avg = en_avg && win_valid_reg;
    assign stage_ctrl.load_out = en_out && avg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            avg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_win)
            begin
                win_valid_reg <= accept;
            end
            if (en_avg)
            begin
                avg_valid_reg <= win_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= avg_valid_reg;
            end
        end
    end

    sbvt_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .sample (sample),
        .win    (win)
    );

    sbvt_detect u_detect (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (stage_ctrl),
        .win         (win),
        .gain_tenths (gain_reg),
        .pulse_ms    (pulse_reg),
        .result      (result)
    );

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> win_valid_reg && avg_valid_reg && out_valid_reg && !result_ready)
        else $error("requests refused while the pipeline has room");

endmodule
`default_nettype wire

// File: tb/sv/sound_burst_vibration_trigger_checker.sv
module sound_burst_vibration_trigger_checker
    import sbvt_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_write,
    input  cfg_index_t               cfg_index,
    input  wire  [CFG_DATA_BITS-1:0] cfg_data,
    input  wire                      sample_valid,
    input  wire                      sample_ready,
    input  sample_t                  sample,
    input  wire                      result_valid,
    input  wire                      result_ready,
    input  result_t                  result,
    output int unsigned              waiting,
    output int unsigned              fault_total
);

    logic [SAMPLE_BITS-1:0] window_copy [WINDOW];
    logic [SUM_BITS-1:0]    window_sum;
    int unsigned            slot;
    logic                   window_filled;
    logic                   vibrating;
    logic [TIME_BITS-1:0]   pulse_origin;
    logic [GAIN_BITS-1:0]   gain_tenths;
    logic [PULSE_BITS-1:0]  pulse_len;
    result_t                due_results [$];
    int unsigned            faults;

    function automatic result_t detect_burst(input sample_t s);
        result_t                r;
        logic [SAMPLE_BITS-1:0] avg;
        // the first request fills the whole window with its baseline
        if (!window_filled)
        begin
            for (int i = 0; i < WINDOW; i++)
                window_copy[i] = s.baseline_sample;
            window_sum    = SUM_BITS'(s.baseline_sample * WINDOW);
            slot          = 0;
            window_filled = 1'b1;
        end
        window_sum = window_sum - SUM_BITS'(window_copy[slot]) + SUM_BITS'(s.baseline_sample);
        window_copy[slot] = s.baseline_sample;
        slot = (slot == WINDOW - 1) ? 0 : slot + 1;
        avg  = SAMPLE_BITS'(window_sum / WINDOW);

        r.trigger_event = (32'(avg) * 32'(gain_tenths)) < (32'(s.current_sample) * 32'd10);
        if (r.trigger_event)
        begin
            vibrating    = 1'b1;
            pulse_origin = s.time_ms;
        end
        // end test is carried out one bit wider, so no wrap
        if (vibrating && (({1'b0, pulse_origin} + 33'(pulse_len)) < {1'b0, s.time_ms}))
            vibrating = 1'b0;

        r.vibrate        = vibrating;
        r.window_average = avg;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                window_copy[i] = '0;
            window_sum    = '0;
            slot          = 0;
            window_filled = 1'b0;
            vibrating     = 1'b0;
            pulse_origin  = '0;
            gain_tenths   = GAIN_RESET;
            pulse_len     = PULSE_RESET;
            faults        = 0;
            due_results.delete();
            waiting     <= 0;
            fault_total <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GAIN_TENTHS: gain_tenths = cfg_data[GAIN_BITS-1:0];
                    REG_PULSE_MS:    pulse_len   = cfg_data[PULSE_BITS-1:0];
                    default: ;
                endcase
            end

            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    if (faults < 10)
                        $display("unexpected result: vibrate %0d event %0d average %0d",
                                 result.vibrate, result.trigger_event, result.window_average);
                    faults++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.vibrate !== want.vibrate ||
                        result.trigger_event !== want.trigger_event ||
                        result.window_average !== want.window_average)
                    begin
                        if (faults < 10)
                            $display("result mismatch: expected vibrate %0d event %0d average %0d,",
                                     want.vibrate, want.trigger_event, want.window_average,
                                     " got vibrate %0d event %0d average %0d",
                                     result.vibrate, result.trigger_event,
                                     result.window_average);
                        faults++;
                    end
                end
            end

            if (sample_valid && sample_ready)
                due_results.push_back(detect_burst(sample));

            waiting     <= due_results.size();
            fault_total <= faults;
        end
    end

endmodule

// File: tb/sv/sound_burst_vibration_trigger_test.sv
module sound_burst_vibration_trigger_test;
    import sbvt_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 200;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     cfg_write    = 1'b0;
    cfg_index_t               cfg_index    = REG_GAIN_TENTHS;
    logic [CFG_DATA_BITS-1:0] cfg_data     = '0;
    logic                     sample_valid = 1'b0;
    logic                     sample_ready;
    sample_t                  sample       = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    result_t                  result;
    logic                     steady_flow  = 1'b0;

    int unsigned          waiting;
    int unsigned          fault_total;
    int unsigned          stall_cycles = 0;
    int unsigned          gain_now     = 13;
    int unsigned          pulse_now    = 300;
    int                   level        = 512;
    logic [TIME_BITS-1:0] clock_ms     = '0;

    sound_burst_vibration_trigger dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    sound_burst_vibration_trigger_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .waiting      (waiting),
        .fault_total  (fault_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_ready <= steady_flow || ($urandom_range(0, 99) >= 16);

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sound_burst_vibration_trigger regression: fail");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] base,
                               input logic [SAMPLE_BITS-1:0] cur,
                               input logic [TIME_BITS-1:0]   stamp);
        while (!steady_flow && $urandom_range(0, 99) < 16)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid           <= 1'b1;
        sample.baseline_sample <= base;
        sample.current_sample  <= cur;
        sample.time_ms         <= stamp;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_until_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input int unsigned gain, input int unsigned pulse);
        cfg_write <= 1'b1;
        cfg_index <= REG_GAIN_TENTHS;
        cfg_data  <= CFG_DATA_BITS'(gain);
        @(posedge clk);
        cfg_index <= REG_PULSE_MS;
        cfg_data  <= CFG_DATA_BITS'(pulse);
        @(posedge clk);
        cfg_write <= 1'b0;
        gain_now  = gain;
        pulse_now = pulse;
    endtask

    // steady baseline around a level, current sample most often near the trip point
    task automatic send_shaped_item();
        int roll;
        int base;
        int cur;
        int bound;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), $urandom);
        else
        begin
            if ($urandom_range(0, 19) == 0)
                level = $urandom_range(0, 1023);
            base = level + int'($urandom_range(0, 16)) - 8;
            if (base < 0)
                base = 0;
            if (base > 1023)
                base = 1023;
            bound = level * int'(gain_now) / 10;
            if (bound > 1023)
                bound = 1023;
            if (roll < 55)
                cur = bound + int'($urandom_range(0, 6)) - 3;
            else if (roll < 80)
                cur = $urandom_range(0, bound);
            else
                cur = $urandom_range(0, 1023);
            if (cur < 0)
                cur = 0;
            if (cur > 1023)
                cur = 1023;
            clock_ms += $urandom_range(0, 2 * pulse_now + 2);
            send_sample(SAMPLE_BITS'(base), SAMPLE_BITS'(cur), clock_ms);
        end
    endtask

    initial
    begin
        int unsigned phase_gain  [6];
        int unsigned phase_pulse [6];
        phase_gain  = '{10, 40, 63, 0, $urandom_range(10, 40), 13};
        phase_pulse = '{1, 65535, 50, 0, $urandom_range(1, 1000), 300};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seeding request sits exactly on the trip point, then one above it
        send_sample(10'd100, 10'd130, 32'd1000);
        send_sample(10'd100, 10'd131, 32'd1000);
        // pulse holds while start + length equals the stamp, drops one later
        send_sample(10'd100, 10'd0, 32'd1300);
        send_sample(10'd100, 10'd0, 32'd1301);
        // start near the top of the stamp range, then a backward stamp
        send_sample(10'd1023, 10'd1023, 32'hFFFF_FFF0);
        send_sample(10'd1023, 10'd0, 32'hFFFF_FFFF);
        send_sample(10'd0, 10'd0, 32'd0);
        repeat (10) send_sample(10'd1023, 10'd0, 32'hFFFF_FFFF);
        send_sample(10'd1023, 10'd1023, 32'hFFFF_FFFF);
        wait_until_drained();

        // zero gain trips on any non-zero sample, zero length ends on a later stamp
        program_registers(0, 0);
        send_sample(10'd0, 10'd1, 32'd5000);
        send_sample(10'd0, 10'd0, 32'd5000);
        send_sample(10'd0, 10'd0, 32'd5001);
        send_sample(10'd0, 10'd0, 32'd5002);
        wait_until_drained();

        program_registers(63, 65535);
        send_sample(10'd1023, 10'd1023, 32'd6000);
        wait_until_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            program_registers(phase_gain[phase], phase_pulse[phase]);
            level       = $urandom_range(0, 1023);
            clock_ms    = $urandom;
            steady_flow <= (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    wait_until_drained();
                send_shaped_item();
            end
            wait_until_drained();
        end

        if (fault_total == 0 && waiting == 0)
            $display("sound_burst_vibration_trigger regression: pass");
        else
            $display("sound_burst_vibration_trigger regression: fail");
        $finish;
    end

endmodule
